// ===== sv/swmma_pkg.sv =====
// Shared types, constants and helpers for the sliding-window min/max/average block.
// Depends on nothing; every other file of the block imports it.
package swmma_pkg;

   localparam int WINDOW_MAX = 256;
   localparam int SLOT_W     = $clog2(WINDOW_MAX);
   localparam int WLEN_W     = SLOT_W + 1;
   localparam int QCNT_W     = SLOT_W + 1;
   localparam int AVG_W      = 40;
   localparam int DIVD_W     = 72;
   localparam int STEP_W     = 7;
   localparam int ADDR_W     = 4;

   localparam logic [STEP_W-1:0] DIV_AVG_STEPS = 7'd72;
   localparam logic [STEP_W-1:0] DIV_MOD_STEPS = 7'd32;
   localparam logic [AVG_W-1:0]  AVG_SAT       = {AVG_W{1'b1}};

   localparam logic [1:0] REG_AGG  = 2'd0;
   localparam logic [1:0] REG_RATE = 2'd1;
   localparam logic [1:0] REG_COL  = 2'd2;

   localparam logic MODE_ADD   = 1'b0;
   localparam logic MODE_QUERY = 1'b1;

   typedef struct packed {
      logic        mode;
      logic [31:0] tick;
      logic [31:0] sample;
   } req_type;

   typedef struct packed {
      logic [AVG_W-1:0] cur_avg;
      logic             cur_valid;
      logic [AVG_W-1:0] window_avg;
      logic             window_avg_valid;
      logic [31:0]      window_min;
      logic             window_min_valid;
      logic [31:0]      window_max;
      logic             window_max_valid;
   } rsp_type;

   typedef struct packed {
      logic [63:0] sum;
      logic [31:0] count;
   } ring_entry_type;

   typedef struct packed {
      logic [31:0] tk;
      logic [31:0] val;
   } qentry_type;

   // command from the sequencer to a monotonic queue
   typedef struct packed {
      logic              is_min;
      logic              nonempty;
      logic [31:0]       value;
      logic [31:0]       tick;
      logic [WLEN_W-1:0] wlen;
   } qcmd_type;

   // status from a monotonic queue
   typedef struct packed {
      logic        done;
      logic        has;
      logic [31:0] front;
   } qstat_type;

   typedef enum logic [3:0] {
      S_IDLE, S_ADV, S_MOD, S_MOD_WAIT, S_LOOP, S_CRD, S_CSUM, S_QWAIT,
      S_SAMPLE, S_QRD, S_DIV1, S_DIV1_WAIT, S_DIV2, S_DIV2_WAIT, S_QMOD, S_QMOD_WAIT
   } seq_state_type;

   typedef enum logic [2:0] {
      Q_IDLE, Q_BACK_RD, Q_BACK_CHK, Q_FRONT_RD, Q_FRONT_CHK, Q_PUSH
   } q_state_type;

   // window length in ticks, clamped to [1, WINDOW_MAX]
   function automatic logic [WLEN_W-1:0] window_len(logic [5:0] at, logic [5:0] ur,
                                                    logic [3:0] col);
      logic [11:0] p;
      p = 12'(at) * 12'(ur);
      if (col[3:1] == 3'b000) return WLEN_W'(1);
      if (p == 12'd0) return WLEN_W'(1);
      if (p > 12'(WINDOW_MAX)) return WLEN_W'(WINDOW_MAX);
      return p[WLEN_W-1:0];
   endfunction

endpackage

// ===== sv/sliding_window_min_max_avg.sv =====
// Sliding-window min/max/average: sequencer, tick ring, APB registers; needs swmma_pkg,
// swmma_div and swmma_queue. One item at a time; busy is high from accept until done.
// Each closed tick stores its bucket in the ring, plus a queue walk when min or max is
// enabled. A tick jump or a register change adds a divide for the ring slot, as does a
// query at tick 0; a query strobes when its two average divides are done. The receiver
// cannot stall; sync reset empties the window.
module sliding_window_min_max_avg (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  swmma_pkg::req_type            req_item,
   output logic                          rsp_valid,
   output swmma_pkg::rsp_type            rsp_item,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [swmma_pkg::ADDR_W-1:0]  paddr,
   input  logic [31:0]                   pwdata,
   output logic [31:0]                   prdata,
   output logic                          pready
);
   import swmma_pkg::*;

   seq_state_type     state_ff, state_in;
   req_type           req_ff;
   logic [5:0]        agg_ff;
   logic [5:0]        rate_ff;
   logic [3:0]        col_ff;
   logic [WLEN_W-1:0] w_ff;
   logic [WLEN_W-1:0] d_ff, d_in;
   logic [31:0]       cur_ff, cur_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic              slot_ok_ff, slot_ok_in;
   logic [31:0]       open_count_ff, open_count_in;
   logic [63:0]       open_sum_ff, open_sum_in;
   logic [31:0]       open_min_ff, open_min_in;
   logic [31:0]       open_max_ff, open_max_in;
   logic [63:0]       total_sum_ff, total_sum_in;
   logic [31:0]       total_count_ff, total_count_in;
   logic              pmin_ff, pmin_in, pmax_ff, pmax_in;
   logic [AVG_W-1:0]  cur_avg_ff, cur_avg_in;
   logic              cur_valid_ff, cur_valid_in;
   rsp_type           rsp_ff, rsp_in;
   logic              rsp_valid_ff, rsp_valid_in;

   ring_entry_type    ring_mem [WINDOW_MAX];
   logic              ring_ok_ff [WINDOW_MAX];
   ring_entry_type    ring_rd_ff;
   logic              ring_rd_ok_ff;
   logic [SLOT_W-1:0] ring_addr;
   logic              ring_we;
   logic [63:0]       ring_sum;
   logic [31:0]       ring_cnt;

   logic              cfg_we;
   logic              div_start, div_done;
   logic [DIVD_W-1:0] div_num;
   logic [31:0]       div_den;
   logic [STEP_W-1:0] div_steps;
   logic [DIVD_W-1:0] div_q;
   logic [31:0]       div_r;
   logic [AVG_W-1:0]  div_avg;

   logic              q_start_min, q_start_max;
   qcmd_type          qcmd_min, qcmd_max;
   qstat_type         qst_min, qst_max;

   logic [31:0]       tick_gap;
   logic [WLEN_W-1:0] wm1;
   logic [SLOT_W-1:0] qidx;
   logic [WLEN_W-1:0] slot_inc;

   assign cfg_we = psel && penable && pwrite;
   assign pready = 1'b1;
   assign busy   = state_ff != S_IDLE;

   // register read
   always_comb begin
      case (paddr[3:2])
         REG_AGG:  prdata = 32'(agg_ff);
         REG_RATE: prdata = 32'(rate_ff);
         REG_COL:  prdata = 32'(col_ff);
         default:  prdata = '0;
      endcase
   end

   // ring read data: a slot never written reads as empty
   assign ring_sum = ring_rd_ok_ff ? ring_rd_ff.sum : '0;
   assign ring_cnt = ring_rd_ok_ff ? ring_rd_ff.count : '0;

   assign tick_gap = req_ff.tick - cur_ff;
   assign wm1      = w_ff - WLEN_W'(1);
   assign qidx     = (slot_ff == '0) ? wm1[SLOT_W-1:0] : slot_ff - 1'b1;
   assign slot_inc = WLEN_W'(slot_ff) + WLEN_W'(1);
   assign div_avg  = (div_q[DIVD_W-1:AVG_W] != '0) ? AVG_SAT : div_q[AVG_W-1:0];

   assign qcmd_min = '{is_min: 1'b1, nonempty: open_count_ff != '0, value: open_min_ff,
                       tick: cur_ff, wlen: w_ff};
   assign qcmd_max = '{is_min: 1'b0, nonempty: open_count_ff != '0, value: open_max_ff,
                       tick: cur_ff, wlen: w_ff};

   // sequencer
   always_comb begin
      state_in       = state_ff;
      d_in           = d_ff;
      cur_in         = cur_ff;
      slot_in        = slot_ff;
      slot_ok_in     = slot_ok_ff;
      open_count_in  = open_count_ff;
      open_sum_in    = open_sum_ff;
      open_min_in    = open_min_ff;
      open_max_in    = open_max_ff;
      total_sum_in   = total_sum_ff;
      total_count_in = total_count_ff;
      pmin_in        = pmin_ff & ~qst_min.done;
      pmax_in        = pmax_ff & ~qst_max.done;
      cur_avg_in     = cur_avg_ff;
      cur_valid_in   = cur_valid_ff;
      rsp_in         = rsp_ff;
      rsp_valid_in   = 1'b0;
      ring_addr      = slot_ff;
      ring_we        = 1'b0;
      div_start      = 1'b0;
      div_num        = {cur_ff, 40'd0};
      div_den        = 32'(w_ff);
      div_steps      = DIV_MOD_STEPS;
      q_start_min    = 1'b0;
      q_start_max    = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (start) state_in = S_ADV;
            if (cfg_we) slot_ok_in = 1'b0;
         end
         S_ADV: begin
            // clamp a large jump to one window of empty ticks
            if (tick_gap > 32'(w_ff)) begin
               cur_in   = req_ff.tick - 32'(w_ff);
               d_in     = w_ff;
               state_in = S_MOD;
            end else begin
               d_in     = tick_gap[WLEN_W-1:0];
               state_in = slot_ok_ff ? S_LOOP : S_MOD;
            end
         end
         S_MOD: begin
            div_start = 1'b1;
            state_in  = S_MOD_WAIT;
         end
         S_MOD_WAIT: begin
            if (div_done) begin
               slot_in    = div_r[SLOT_W-1:0];
               slot_ok_in = 1'b1;
               state_in   = S_LOOP;
            end
         end
         S_LOOP: begin
            if (d_ff != '0) state_in = S_CRD;
            else if (req_ff.mode == MODE_ADD) state_in = S_SAMPLE;
            else if (cur_ff == '0) state_in = S_QMOD;
            else state_in = S_QRD;
         end
         S_CRD: begin
            // retire the old slot and store the closed bucket
            total_count_in = total_count_ff - ring_cnt + open_count_ff;
            total_sum_in   = total_sum_ff - ring_sum;
            ring_we        = 1'b1;
            state_in       = S_CSUM;
         end
         S_CSUM: begin
            total_sum_in = total_sum_ff + open_sum_ff;
            q_start_min  = col_ff[2];
            q_start_max  = col_ff[3];
            pmin_in      = col_ff[2];
            pmax_in      = col_ff[3];
            state_in     = S_QWAIT;
         end
         S_QWAIT: begin
            if (!pmin_in && !pmax_in) begin
               open_count_in = '0;
               open_sum_in   = '0;
               open_min_in   = '0;
               open_max_in   = '0;
               cur_in        = cur_ff + 1'b1;
               // the tick count wrapping to zero restarts the ring at slot zero
               slot_in       = (cur_ff == '1 || slot_inc == w_ff) ? '0 :
                               slot_inc[SLOT_W-1:0];
               d_in          = d_ff - 1'b1;
               state_in      = S_LOOP;
            end
         end
         S_SAMPLE: begin
            if (open_count_ff == '0) begin
               open_min_in = req_ff.sample;
               open_max_in = req_ff.sample;
            end else if (req_ff.sample < open_min_ff) begin
               open_min_in = req_ff.sample;
            end else if (req_ff.sample > open_max_ff) begin
               open_max_in = req_ff.sample;
            end
            // a saturated bucket keeps its count and sum
            if (open_count_ff != '1) begin
               open_count_in = open_count_ff + 1'b1;
               open_sum_in   = open_sum_ff + 64'(req_ff.sample);
            end
            state_in = S_IDLE;
         end
         S_QRD: begin
            ring_addr = qidx;
            state_in  = S_DIV1;
         end
         S_QMOD: begin
            // at tick zero the previous tick wraps to all ones: take its residue
            div_start = 1'b1;
            div_num   = {32'hFFFF_FFFF, 40'd0};
            state_in  = S_QMOD_WAIT;
         end
         S_QMOD_WAIT: begin
            if (div_done) begin
               ring_addr = div_r[SLOT_W-1:0];
               state_in  = S_DIV1;
            end
         end
         S_DIV1: begin
            div_start    = 1'b1;
            div_num      = {ring_sum, 8'd0};
            div_den      = ring_cnt;
            div_steps    = DIV_AVG_STEPS;
            cur_valid_in = col_ff[0] && ring_cnt != '0;
            state_in     = S_DIV1_WAIT;
         end
         S_DIV1_WAIT: begin
            if (div_done) begin
               cur_avg_in = cur_valid_ff ? div_avg : '0;
               state_in   = S_DIV2;
            end
         end
         S_DIV2: begin
            div_start = 1'b1;
            div_num   = {total_sum_ff, 8'd0};
            div_den   = total_count_ff;
            div_steps = DIV_AVG_STEPS;
            state_in  = S_DIV2_WAIT;
         end
         S_DIV2_WAIT: begin
            if (div_done) begin
               rsp_in.cur_avg          = cur_avg_ff;
               rsp_in.cur_valid        = cur_valid_ff;
               rsp_in.window_avg_valid = col_ff[1] && total_count_ff != '0;
               rsp_in.window_avg       = rsp_in.window_avg_valid ? div_avg : '0;
               rsp_in.window_min_valid = qst_min.has;
               rsp_in.window_min       = qst_min.has ? qst_min.front : '0;
               rsp_in.window_max_valid = qst_max.has;
               rsp_in.window_max       = qst_max.has ? qst_max.front : '0;
               rsp_valid_in            = 1'b1;
               state_in                = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // state and architectural registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         agg_ff         <= 6'd3;
         rate_ff        <= 6'd5;
         col_ff         <= 4'hF;
         d_ff           <= '0;
         cur_ff         <= '0;
         slot_ff        <= '0;
         slot_ok_ff     <= 1'b1;
         open_count_ff  <= '0;
         open_sum_ff    <= '0;
         open_min_ff    <= '0;
         open_max_ff    <= '0;
         total_sum_ff   <= '0;
         total_count_ff <= '0;
         pmin_ff        <= 1'b0;
         pmax_ff        <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         d_ff           <= d_in;
         cur_ff         <= cur_in;
         slot_ff        <= slot_in;
         slot_ok_ff     <= slot_ok_in;
         open_count_ff  <= open_count_in;
         open_sum_ff    <= open_sum_in;
         open_min_ff    <= open_min_in;
         open_max_ff    <= open_max_in;
         total_sum_ff   <= total_sum_in;
         total_count_ff <= total_count_in;
         pmin_ff        <= pmin_in;
         pmax_ff        <= pmax_in;
         rsp_valid_ff   <= rsp_valid_in;
         if (cfg_we) begin
            case (paddr[3:2])
               REG_AGG:  agg_ff  <= pwdata[5:0];
               REG_RATE: rate_ff <= pwdata[5:0];
               REG_COL:  col_ff  <= pwdata[3:0];
               default:  ;
            endcase
         end
      end
   end

   // item payload and result registers
   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && start) begin
         req_ff <= req_item;
         w_ff   <= window_len(agg_ff, rate_ff, col_ff);
      end
      cur_avg_ff   <= cur_avg_in;
      cur_valid_ff <= cur_valid_in;
      rsp_ff       <= rsp_in;
   end

   // ring valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < WINDOW_MAX; i++) ring_ok_ff[i] <= 1'b0;
      end else if (ring_we) begin
         ring_ok_ff[slot_ff] <= 1'b1;
      end
   end

   // ring store
   always_ff @(posedge clock) begin
      if (ring_we) ring_mem[slot_ff] <= '{sum: open_sum_ff, count: open_count_ff};
      ring_rd_ff    <= ring_mem[ring_addr];
      ring_rd_ok_ff <= ring_ok_ff[ring_addr];
   end

   swmma_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_num),
      .divisor   (div_den),
      .steps     (div_steps),
      .done      (div_done),
      .quotient  (div_q),
      .remainder (div_r)
   );

   swmma_queue u_qmin (
      .clock (clock),
      .reset (reset),
      .start (q_start_min),
      .cmd   (qcmd_min),
      .stat  (qst_min)
   );

   swmma_queue u_qmax (
      .clock (clock),
      .reset (reset),
      .start (q_start_max),
      .cmd   (qcmd_max),
      .stat  (qst_max)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   // the walk never runs past the window, and the slot stays inside it
   a_walk_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_LOOP) |-> (d_ff <= w_ff))
      else $error("closing walk longer than the window");

   a_slot_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_LOOP) |-> (slot_ok_ff && WLEN_W'(slot_ff) < w_ff))
      else $error("ring slot outside the window");

   a_rsp_src: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(state_ff == S_DIV2_WAIT && div_done))
      else $error("result shown without a finished query");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted item did not raise busy");

   a_queue_wait: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CSUM) |=> (state_ff == S_QWAIT))
      else $error("queue update skipped");

endmodule

// ===== sv/swmma_div.sv =====
// Shared restoring divider, one quotient bit a cycle.
// Depends on swmma_pkg.
module swmma_div (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [swmma_pkg::DIVD_W-1:0]    dividend,
   input  logic [31:0]                     divisor,
   input  logic [swmma_pkg::STEP_W-1:0]    steps,
   output logic                            done,
   output logic [swmma_pkg::DIVD_W-1:0]    quotient,
   output logic [31:0]                     remainder
);
   import swmma_pkg::*;

   logic [DIVD_W-1:0] num_ff;
   logic [31:0]       rem_ff;
   logic [31:0]       den_ff;
   logic [STEP_W-1:0] left_ff;
   logic              run_ff;
   logic              done_ff;
   logic [32:0]       trial;
   logic [32:0]       diff;
   logic              fit;

   // trial subtract of the shifted remainder
   always_comb begin
      trial = {rem_ff, num_ff[DIVD_W-1]};
      diff  = trial - {1'b0, den_ff};
      fit   = trial >= {1'b0, den_ff};
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         left_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff  <= 1'b1;
            left_ff <= steps;
         end else if (run_ff) begin
            left_ff <= left_ff - 1'b1;
            if (left_ff == STEP_W'(1)) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (start) begin
         num_ff <= dividend;
         rem_ff <= '0;
         den_ff <= divisor;
      end else if (run_ff) begin
         rem_ff <= fit ? diff[31:0] : trial[31:0];
         num_ff <= {num_ff[DIVD_W-2:0], fit};
      end
   end

   assign done      = done_ff;
   assign quotient  = num_ff;
   assign remainder = rem_ff;

endmodule

// ===== sv/swmma_queue.sv =====
// Monotonic queue of tick:value entries for the window minimum or maximum.
// Depends on swmma_pkg; holds its entries in a local memory.
module swmma_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  swmma_pkg::qcmd_type   cmd,
   output swmma_pkg::qstat_type  stat
);
   import swmma_pkg::*;

   q_state_type       state_ff, state_in;
   qcmd_type          cmd_ff;
   logic [SLOT_W-1:0] head_ff, head_in;
   logic [QCNT_W-1:0] cnt_ff, cnt_in;
   qentry_type        mem [WINDOW_MAX];
   qentry_type        rd_ff;
   logic [SLOT_W-1:0] rd_addr;
   logic [SLOT_W-1:0] wr_addr;
   logic              wr_en;
   logic              done_in, done_ff;
   logic              drop;
   logic [31:0]       age;

   // next state: pop back, expire front, push
   always_comb begin
      state_in = state_ff;
      head_in  = head_ff;
      cnt_in   = cnt_ff;
      rd_addr  = head_ff;
      wr_addr  = head_ff + cnt_ff[SLOT_W-1:0];
      wr_en    = 1'b0;
      done_in  = 1'b0;
      drop     = cmd_ff.is_min ? (cmd_ff.value <= rd_ff.val) : (cmd_ff.value >= rd_ff.val);
      age      = cmd_ff.tick - rd_ff.tk;
      case (state_ff)
         Q_IDLE: begin
            if (start) state_in = Q_BACK_RD;
         end
         Q_BACK_RD: begin
            rd_addr = head_ff + cnt_ff[SLOT_W-1:0] - 1'b1;
            if (cmd_ff.nonempty && cnt_ff != '0) state_in = Q_BACK_CHK;
            else state_in = Q_FRONT_RD;
         end
         Q_BACK_CHK: begin
            if (drop) begin
               cnt_in   = cnt_ff - 1'b1;
               state_in = Q_BACK_RD;
            end else begin
               state_in = Q_FRONT_RD;
            end
         end
         Q_FRONT_RD: begin
            if (cnt_ff != '0) state_in = Q_FRONT_CHK;
            else state_in = Q_PUSH;
         end
         Q_FRONT_CHK: begin
            if (age >= 32'(cmd_ff.wlen)) begin
               head_in  = head_ff + 1'b1;
               cnt_in   = cnt_ff - 1'b1;
               state_in = Q_FRONT_RD;
            end else begin
               state_in = Q_PUSH;
            end
         end
         Q_PUSH: begin
            if (cmd_ff.nonempty) begin
               wr_en = 1'b1;
               // full: drop the front, the new entry takes its place
               if (cnt_ff == QCNT_W'(WINDOW_MAX)) head_in = head_ff + 1'b1;
               else cnt_in = cnt_ff + 1'b1;
            end
            done_in  = 1'b1;
            state_in = Q_IDLE;
         end
         default: state_in = Q_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= Q_IDLE;
         head_ff  <= '0;
         cnt_ff   <= '0;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         cnt_ff   <= cnt_in;
         done_ff  <= done_in;
      end
   end

   // hold the command for the whole update
   always_ff @(posedge clock) begin
      if (state_ff == Q_IDLE && start) cmd_ff <= cmd;
   end

   // entry store
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= '{tk: cmd_ff.tick, val: cmd_ff.value};
      rd_ff <= mem[rd_addr];
   end

   assign stat.done  = done_ff;
   assign stat.has   = cnt_ff != '0;
   assign stat.front = rd_ff.val;

endmodule
